/* rtl/core/bpp_pkg.sv */
// Shared types, constants and code tables for the board position packer.
// Used by the front classifier, the command queue and the back end.
// Depends on nothing.
package bpp_pkg;

  localparam int unsigned PACKED_BITS  = 256;
  localparam int unsigned CURSOR_W     = 9;
  localparam int unsigned SQ_W         = 7;
  localparam int unsigned WORD_W       = 64;
  localparam int unsigned GRP_W        = 8;
  localparam int unsigned GRP_LEN_W    = 4;
  localparam int unsigned REP_W        = 5;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_SQUARE = 2'd1;
  localparam logic [1:0] OP_HAND = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_LENGTH = 2'd1;
  localparam logic [1:0] STATUS_NO_KING = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

  localparam logic [2:0] TYPE_GOLD = 3'd7;
  localparam logic [3:0] KING_CODE = 4'd8;

  localparam logic [CURSOR_W-1:0] START_CURSOR = 9'd15;
  localparam logic [CURSOR_W-1:0] CURSOR_FULL = 9'd256;
  localparam logic [SQ_W-1:0] SQ_MAX = 7'd127;
  localparam int unsigned BLACK_KING_SLOT = 1;
  localparam int unsigned WHITE_KING_SLOT = 8;

  localparam logic [GRP_W-1:0] CODE_VAL [8] = '{
    8'h00, 8'h01, 8'h03, 8'h0b, 8'h07, 8'h1f, 8'h3f, 8'h0f
  };
  localparam logic [GRP_LEN_W-1:0] CODE_LEN [8] = '{
    4'd1, 4'd2, 4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd5
  };

  typedef enum logic [1:0] {
    K_START = 2'd0,
    K_WRITE = 2'd1,
    K_KING  = 2'd2,
    K_NOP   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [GRP_W-1:0]     bits;
    logic [GRP_LEN_W-1:0] len;
  } grp_t;

  typedef struct packed {
    kind_t            kind;
    grp_t             grp;
    logic [REP_W-1:0] rep;
    logic             sq_inc;
    logic             colour;
    logic             last;
  } cmd_t;

  function automatic grp_t square_group(input logic [4:0] piece);
    grp_t g;
    logic [2:0] pt;
    pt = piece[2:0];
    g.bits = CODE_VAL[pt];
    g.len = CODE_LEN[pt];
    if (piece != 5'd0) begin
      if (pt != TYPE_GOLD) begin
        g.bits = g.bits | (GRP_W'(piece[3]) << g.len);
        g.len = g.len + 4'd1;
      end
      g.bits = g.bits | (GRP_W'(piece[4]) << g.len);
      g.len = g.len + 4'd1;
    end
    return g;
  endfunction

  function automatic grp_t hand_group(input logic [2:0] htype, input logic colour);
    grp_t g;
    g.bits = CODE_VAL[htype] >> 1;
    g.len = CODE_LEN[htype] - 4'd1;
    if (htype != TYPE_GOLD) begin
      g.len = g.len + 4'd1;
    end
    g.bits = g.bits | (GRP_W'(colour) << g.len);
    g.len = g.len + 4'd1;
    return g;
  endfunction

endpackage

/* rtl/core/bpp_front.sv */
// Front end: accepts input transactions and classifies them into commands.
// Depends on bpp_pkg for the command type and the code tables.
module bpp_front import bpp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic       in_side_to_move,
  input  logic [4:0] in_piece,
  input  logic       in_hand_color,
  input  logic [2:0] in_hand_type,
  input  logic [4:0] in_hand_count,
  input  logic       in_last,
  output logic       push_valid,
  input  logic       push_ready,
  output cmd_t       push_cmd
);

  logic busy_r;
  logic busy_nxt;

  // Tracks whether a transaction is being handed to the queue this cycle.
  assign busy_nxt = in_valid & push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign in_ready   = push_ready | (busy_r & 1'b0);
  assign push_valid = in_valid;

  always_comb begin
    push_cmd        = '0;
    push_cmd.kind   = K_NOP;
    push_cmd.last   = in_last;
    case (in_operation)
      OP_START: begin
        push_cmd.kind   = K_START;
        push_cmd.colour = in_side_to_move;
      end
      OP_SQUARE: begin
        push_cmd.sq_inc = 1'b1;
        push_cmd.colour = in_piece[4];
        if (in_piece[3:0] == KING_CODE) begin
          push_cmd.kind = K_KING;
        end else begin
          push_cmd.kind = K_WRITE;
          push_cmd.grp  = square_group(in_piece);
          push_cmd.rep  = REP_W'(1);
        end
      end
      OP_HAND: begin
        push_cmd.kind   = K_WRITE;
        push_cmd.colour = in_hand_color;
        push_cmd.grp    = hand_group(in_hand_type, in_hand_color);
        push_cmd.rep    = in_hand_count;
      end
      default: begin
        push_cmd.kind = K_NOP;
      end
    endcase
  end

endmodule

/* rtl/core/bpp_queue.sv */
// Two-entry command queue between the front classifier and the back end.
// Depends on bpp_pkg for the command type.
module bpp_queue import bpp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = q_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  assign wr_ptr_nxt = wr_ptr_r ^ push;
  assign rd_ptr_nxt = rd_ptr_r ^ pop;
  assign cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/core/bpp_back.sv */
// Back end: executes commands on the 256-bit record and streams out the words.
// Depends on bpp_pkg for the command type, constants and status codes.
module bpp_back import bpp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WORD_W-1:0]  out_packed_word,
  output logic               out_word_last,
  output logic [1:0]         out_status
);

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t                 st_r, st_nxt;
  logic [PACKED_BITS-1:0] rec_r, rec_nxt;
  logic [CURSOR_W-1:0]    cur_r, cur_nxt;
  logic [SQ_W-1:0]        sq_r, sq_nxt;
  logic [1:0]             kings_r, kings_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [REP_W-1:0]       rep_r, rep_nxt;
  logic [1:0]             widx_r, widx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]      out_word_r, out_word_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [1:0]             out_status_r, out_status_nxt;

  logic                   pop;
  logic                   load;
  logic [1:0]             status;
  logic [PACKED_BITS-1:0] ins_mask;
  logic [CURSOR_W:0]      cur_sum;

  assign ins_mask = PACKED_BITS'(cmd.grp.bits) << cur_r[CURSOR_W-2:0];
  assign cur_sum  = {1'b0, cur_r} + (CURSOR_W+1)'(cmd.grp.len);

  always_comb begin
    if (ovf_r) begin
      status = STATUS_OVERFLOW;
    end else if (kings_r != 2'b11) begin
      status = STATUS_NO_KING;
    end else if (cur_r != CURSOR_FULL) begin
      status = STATUS_LENGTH;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    rec_nxt   = rec_r;
    cur_nxt   = cur_r;
    sq_nxt    = sq_r;
    kings_nxt = kings_r;
    ovf_nxt   = ovf_r;
    rep_nxt   = rep_r;
    widx_nxt  = widx_r;
    pop       = 1'b0;

    if (st_r == ST_RUN && cmd_valid) begin
      case (cmd.kind)
        K_START: begin
          rec_nxt    = '0;
          rec_nxt[0] = cmd.colour;
          cur_nxt    = START_CURSOR;
          sq_nxt     = '0;
          kings_nxt  = '0;
          ovf_nxt    = 1'b0;
          pop        = 1'b1;
        end
        K_WRITE: begin
          if (cmd.rep == '0) begin
            pop = 1'b1;
          end else begin
            if (cur_r[CURSOR_W-1]) begin
              ovf_nxt = 1'b1;
            end else begin
              rec_nxt = rec_r | ins_mask;
              if (cur_sum > (CURSOR_W+1)'(CURSOR_FULL)) begin
                cur_nxt = CURSOR_FULL;
                ovf_nxt = 1'b1;
              end else begin
                cur_nxt = cur_sum[CURSOR_W-1:0];
              end
            end
            if (rep_r == REP_W'(cmd.rep - REP_W'(1))) begin
              pop     = 1'b1;
              rep_nxt = '0;
            end else begin
              rep_nxt = rep_r + REP_W'(1);
            end
          end
        end
        K_KING: begin
          if (!kings_r[cmd.colour]) begin
            if (cmd.colour) begin
              rec_nxt[WHITE_KING_SLOT +: SQ_W] = sq_r;
            end else begin
              rec_nxt[BLACK_KING_SLOT +: SQ_W] = sq_r;
            end
            kings_nxt[cmd.colour] = 1'b1;
          end
          pop = 1'b1;
        end
        default: begin
          pop = 1'b1;
        end
      endcase
      if (pop && cmd.sq_inc && sq_r != SQ_MAX) begin
        sq_nxt = sq_r + SQ_W'(1);
      end
      if (pop && cmd.last) begin
        st_nxt   = ST_EMIT;
        widx_nxt = '0;
      end
    end
  end

  assign load = (st_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_word_nxt   = out_word_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_word_nxt   = rec_r[{widx_r, 6'd0} +: WORD_W];
      out_last_nxt   = (widx_r == 2'd3);
      out_status_nxt = status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RUN;
      rec_r       <= '0;
      cur_r       <= '0;
      sq_r        <= '0;
      kings_r     <= '0;
      ovf_r       <= 1'b0;
      rep_r       <= '0;
      widx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rec_r       <= rec_nxt;
      cur_r       <= cur_nxt;
      sq_r        <= sq_nxt;
      kings_r     <= kings_nxt;
      ovf_r       <= ovf_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
      if (load) begin
        widx_r <= widx_r + 2'd1;
        if (widx_r == 2'd3) begin
          st_r <= ST_RUN;
        end
      end else begin
        widx_r <= widx_nxt;
        st_r   <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r   <= out_word_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign cmd_ready       = pop;
  assign out_valid       = out_valid_r;
  assign out_packed_word = out_word_r;
  assign out_word_last   = out_last_r;
  assign out_status      = out_status_r;

endmodule

/* rtl/core/board_position_huffman_packer.sv */
// Top level of the board position packer: front classifier, queue and back end.
// Depends on bpp_pkg, bpp_front, bpp_queue and bpp_back.
//
// The block builds a 256-bit packed position from a stream of transactions.
// The front accepts one transaction per cycle, while the queue has room, into a two-entry command queue.
// The back end, which writes at most one code group per cycle into the record,
// sets the rate: a hand transaction writes its code group once for each piece
// in its count, and a transaction marked last is followed by loading the four
// 64-bit words into the output register in turn, held while the output is
// stalled. No further commands are executed until the fourth word has been
// loaded.
module board_position_huffman_packer import bpp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic              in_side_to_move,
  input  logic [4:0]        in_piece,
  input  logic              in_hand_color,
  input  logic [2:0]        in_hand_type,
  input  logic [4:0]        in_hand_count,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_packed_word,
  output logic              out_word_last,
  output logic [1:0]        out_status
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  bpp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_side_to_move (in_side_to_move),
    .in_piece        (in_piece),
    .in_hand_color   (in_hand_color),
    .in_hand_type    (in_hand_type),
    .in_hand_count   (in_hand_count),
    .in_last         (in_last),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_cmd        (push_cmd)
  );

  bpp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (cmd_valid),
    .pop_ready  (cmd_ready),
    .pop_cmd    (cmd)
  );

  bpp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd             (cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_word (out_packed_word),
    .out_word_last   (out_word_last),
    .out_status      (out_status)
  );

endmodule
